// ----- hw/rtl/twfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed waveform table player package
// Shared sizes, operation and register codes, and the sample conversion
// functions of the waveform table player.
// ----------------------------------------------------------------------------
`default_nettype none

package twfp_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH  = 1024;
	localparam int SAMPLE_WIDTH = 32;
	localparam int TBL_AW       = $clog2(TABLE_DEPTH);

	// Divider sizes: the divisor holds either the interval or the entry count.
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int DIV_W  = (CNT_W > 16) ? CNT_W : 16;
	localparam int DVD_W  = 33;
	localparam int STEP_W = $clog2(DVD_W + 1);

	// Operation codes carried on the input tuser.
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ARM  = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	// Configuration register indexes.
	localparam int          CFG_IDX_W    = 3;
	localparam logic [2:0] REG_START    = 3'd0;
	localparam logic [2:0] REG_DURATION = 3'd1;
	localparam logic [2:0] REG_INTERVAL = 3'd2;
	localparam logic [2:0] REG_PHASE    = 3'd3;
	localparam logic [2:0] REG_COUNT    = 3'd4;
	localparam logic [2:0] REG_STEP     = 3'd5;

	// A loaded 32-bit value is sign-extended and kept in SAMPLE_WIDTH bits.
	function automatic logic [SAMPLE_WIDTH-1:0] to_stored(input logic [31:0] v);
		logic signed [63:0] e;
		e = 64'(signed'(v));
		return e[SAMPLE_WIDTH-1:0];
	endfunction

	// A stored sample is sign-extended from SAMPLE_WIDTH bits, then cut to 32.
	function automatic logic [31:0] from_stored(input logic [SAMPLE_WIDTH-1:0] s);
		logic signed [63:0] e;
		e = 64'(signed'(s));
		return e[31:0];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/twfp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module twfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/twfp_div.sv -----
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Produces one quotient bit per cycle; quotient and remainder are valid while
// done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module twfp_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [twfp_pkg::DVD_W-1:0] dividend,
	input  wire logic [twfp_pkg::DIV_W-1:0] divisor,
	output logic                             busy,
	output logic                             done,
	output logic      [twfp_pkg::DVD_W-1:0] quot,
	output logic      [twfp_pkg::DIV_W-1:0] rem
);

	logic                         busy_q;
	logic                         done_q;
	logic [twfp_pkg::STEP_W-1:0]  step_q;
	logic [twfp_pkg::DVD_W-1:0]   dvd_q;
	logic [twfp_pkg::DIV_W-1:0]   rem_q;
	logic [twfp_pkg::DIV_W-1:0]   dvs_q;

	logic [twfp_pkg::DIV_W:0]     trial;
	logic [twfp_pkg::DIV_W+1:0]   diff;
	logic                         ge;

	// One restoring step: bring down the next dividend bit and try a subtract.
	assign trial = {rem_q, dvd_q[twfp_pkg::DVD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign ge    = ~diff[twfp_pkg::DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == twfp_pkg::STEP_W'(twfp_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[twfp_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? diff[twfp_pkg::DIV_W-1:0] : trial[twfp_pkg::DIV_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/timed_waveform_table_player.sv -----
// ----------------------------------------------------------------------------
// Timed waveform table player
// Plays a loaded sample table back as a waveform paced by tick transfers.
// ----------------------------------------------------------------------------
// Handling: a load, an arm or a tick while stopped is taken in the idle state; a tick
// before the start time passes CHK1 and CHK2; the stopping tick passes CHK1, CHK2 and
// EMIT; a tick off the sample grid adds one divider pass in MOD; a sample tick goes on
// through MOD, DIV, WRAP, READ and EMIT (three passes through the shared one-bit-per-cycle divider).
// Throughput is one item at a time; a held result stalls the sequencer at the end.
// Reset restores the default configuration and clears the time and running flag.
`default_nettype none

module timed_waveform_table_player (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// Configuration write port.
	input  wire logic                                cfg_we,
	input  wire logic [twfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [31:0]                         cfg_data,

	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // [9:0] load_index, [41:10] load_value, rest zero
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation

	// Result stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,  // [31:0] sample
	output logic             m_axis_tlast   // finished
);

	// Sequencer states, one-hot.
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,  // ready for the next transfer
		ST_CHK1 = 8'b0000_0010,  // end time, start compare, time minus start
		ST_CHK2 = 8'b0000_0100,  // decide silent, stop or sample; add phase
		ST_MOD  = 8'b0000_1000,  // time modulo interval
		ST_DIV  = 8'b0001_0000,  // offset divided by interval
		ST_WRAP = 8'b0010_0000,  // quotient modulo count
		ST_READ = 8'b0100_0000,  // table read in flight
		ST_EMIT = 8'b1000_0000   // load the output register
	} state_t;

	state_t st_q;

	// Configuration registers.
	logic [31:0] start_q;
	logic [31:0] dur_q;
	logic [15:0] intv_q;
	logic [31:0] phase_q;
	logic [10:0] count_q;
	logic [15:0] step_q;

	// Playback state.
	logic [31:0] time_q;
	logic        running_q;

	// Working registers of one tick.
	logic [32:0] end_q;
	logic        ge_start_q;
	logic [31:0] diff_q;
	logic [32:0] x_q;
	logic        fin_q;
	logic [twfp_pkg::TBL_AW-1:0] rd_addr_q;

	// Output register.
	logic        m_valid_q;
	logic [31:0] m_data_q;
	logic        m_last_q;

	// Input fields.
	logic [1:0]  in_op;
	logic [9:0]  in_index;
	logic [31:0] in_value;
	logic        in_xfer;

	assign in_op    = s_axis_tuser;
	assign in_index = s_axis_tdata[9:0];
	assign in_value = s_axis_tdata[41:10];

	assign s_axis_tready = (st_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// A zero interval acts as one; the count is clamped to one..TABLE_DEPTH.
	logic [twfp_pkg::DIV_W-1:0] int_norm;
	logic [twfp_pkg::DIV_W-1:0] cnt_norm;

	assign int_norm = (intv_q == 16'd0) ? twfp_pkg::DIV_W'(1)
	                                    : twfp_pkg::DIV_W'(intv_q);

	always_comb begin
		if (count_q == 11'd0) begin
			cnt_norm = twfp_pkg::DIV_W'(1);
		end else if (32'(count_q) > twfp_pkg::TABLE_DEPTH) begin
			cnt_norm = twfp_pkg::DIV_W'(twfp_pkg::TABLE_DEPTH);
		end else begin
			cnt_norm = twfp_pkg::DIV_W'(count_q);
		end
	end

	// Saturating time advance.
	logic [32:0] adv_sum;
	logic [31:0] time_adv;

	assign adv_sum  = {1'b0, time_q} + 33'(step_q);
	assign time_adv = adv_sum[32] ? 32'hFFFF_FFFF : adv_sum[31:0];

	// Shared divider. The three passes are time mod interval, offset divided
	// by interval, and that quotient mod count.
	logic                        div_start;
	logic [twfp_pkg::DVD_W-1:0]  div_dvd;
	logic [twfp_pkg::DIV_W-1:0]  div_dvs;
	logic                        div_busy;
	logic                        div_done;
	logic [twfp_pkg::DVD_W-1:0]  div_quot;
	logic [twfp_pkg::DIV_W-1:0]  div_rem;
	logic                        chk_stop;

	assign chk_stop = ({1'b0, time_q} >= end_q);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = {1'b0, time_q};
		div_dvs   = int_norm;
		case (st_q)
			ST_CHK2: begin
				div_start = ge_start_q && !chk_stop;
			end
			ST_MOD: begin
				div_start = div_done && (div_rem == '0);
				div_dvd   = x_q;
			end
			ST_DIV: begin
				div_start = div_done;
				div_dvd   = div_quot;
				div_dvs   = cnt_norm;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	twfp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Sample table. Loads beyond the table depth are dropped.
	logic                           tbl_we;
	logic [twfp_pkg::SAMPLE_WIDTH-1:0] tbl_rdata;

	assign tbl_we = in_xfer && (in_op == twfp_pkg::OP_LOAD)
	                && (32'(in_index) < twfp_pkg::TABLE_DEPTH);

	twfp_ram #(
		.WIDTH (twfp_pkg::SAMPLE_WIDTH),
		.DEPTH (twfp_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (twfp_pkg::TBL_AW'(in_index)),
		.wdata (twfp_pkg::to_stored(in_value)),
		.raddr (rd_addr_q),
		.rdata (tbl_rdata)
	);

	// The output register may be loaded once the previous result has been
	// taken or is being taken in this cycle.
	logic out_free;
	assign out_free = !m_valid_q || m_axis_tready;

	// Configuration writes must arrive only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			dur_q   <= '0;
			intv_q  <= 16'd1;
			phase_q <= '0;
			count_q <= 11'd1;
			step_q  <= 16'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				twfp_pkg::REG_START:    start_q <= cfg_data;
				twfp_pkg::REG_DURATION: dur_q   <= cfg_data;
				twfp_pkg::REG_INTERVAL: intv_q  <= cfg_data[15:0];
				twfp_pkg::REG_PHASE:    phase_q <= cfg_data;
				twfp_pkg::REG_COUNT:    count_q <= cfg_data[10:0];
				twfp_pkg::REG_STEP:     step_q  <= cfg_data[15:0];
				default:                ;
			endcase
		end
	end

	// Sequencer, playback state and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			time_q    <= '0;
			running_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one being taken; otherwise a taken
			// result empties the output register.
			if (st_q == ST_EMIT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (in_op)
							twfp_pkg::OP_ARM: begin
								time_q    <= '0;
								running_q <= 1'b1;
							end
							twfp_pkg::OP_TICK: begin
								if (running_q) begin
									st_q <= ST_CHK1;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CHK1: begin
					st_q <= ST_CHK2;
				end
				ST_CHK2: begin
					// Before the start time the tick only advances the time.
					// The tick that reaches the end time stops playback and
					// leaves the time where it is.
					if (!ge_start_q) begin
						time_q <= time_adv;
						st_q   <= ST_IDLE;
					end else if (chk_stop) begin
						running_q <= 1'b0;
						st_q      <= ST_EMIT;
					end else begin
						st_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (div_done) begin
						if (div_rem != '0) begin
							time_q <= time_adv;
							st_q   <= ST_IDLE;
						end else begin
							st_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						st_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (div_done) begin
						st_q <= ST_READ;
					end
				end
				ST_READ: begin
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (!fin_q) begin
							time_q <= time_adv;
						end
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working and output payload registers.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_CHK1: begin
				end_q      <= {1'b0, start_q} + {1'b0, dur_q};
				ge_start_q <= (time_q >= start_q);
				diff_q     <= time_q - start_q;
			end
			ST_CHK2: begin
				x_q   <= {1'b0, diff_q} + {1'b0, phase_q};
				fin_q <= 1'b1;
			end
			ST_WRAP: begin
				if (div_done) begin
					rd_addr_q <= div_rem[twfp_pkg::TBL_AW-1:0];
					fin_q     <= 1'b0;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					m_data_q <= fin_q ? 32'd0 : twfp_pkg::from_stored(tbl_rdata);
					m_last_q <= fin_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
	// The divider is never working while new transfers are taken.
	a_idle_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_busy)
		else $error("divider busy while accepting input");

	// A finished result always carries a zero sample.
	a_finished_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == 32'd0))
		else $error("finished result with nonzero sample");

	// The table index always lies within the entries in use.
	a_index_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_READ) |-> (twfp_pkg::DIV_W'(rd_addr_q) < cnt_norm))
		else $error("table index outside sample count");

	// Divider results only arrive while the sequencer waits for them.
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (st_q == ST_MOD || st_q == ST_DIV || st_q == ST_WRAP))
		else $error("divider finished in an unexpected state");
`endif

endmodule

`default_nettype wire
